### src/rx_ring_command_extractor_unit_defines.svh
// ----------------------------------------------------------------------------
// rx ring command extractor - assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef RX_RING_COMMAND_EXTRACTOR_UNIT_DEFINES_SVH
`define RX_RING_COMMAND_EXTRACTOR_UNIT_DEFINES_SVH

// condition must hold at every edge out of reset
`define RXRCE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// consequence must hold in the cycle after the antecedent
`define RXRCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define RXRCE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/rxrce_pkg.sv
// ----------------------------------------------------------------------------
// rxrce_pkg
// types and constants shared by the rx ring command extractor
// ----------------------------------------------------------------------------
package rxrce_pkg;

  // default ring depth
  localparam int unsigned BufDepthDefault = 64;

  // framing characters
  localparam logic [7:0] CharTerm = 8'h3B;
  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;

  // item operation codes
  localparam logic OpByte  = 1'b0;
  localparam logic OpFetch = 1'b1;

  // input item
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  // result item
  typedef struct packed {
    logic       found;
    logic [7:0] cmd_char;
    logic       last;
  } out_t;

  // controller states
  typedef enum logic {
    StIdle,
    StDrain
  } state_e;

  // controller status, watched by the top level checks
  typedef struct packed {
    logic drain;
    logic term_zero;
  } status_t;

endpackage

### src/rxrce_ring_mem.sv
// ----------------------------------------------------------------------------
// rxrce_ring_mem
// ring byte store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rxrce_ring_mem #(
  parameter int unsigned BUF_DEPTH = rxrce_pkg::BufDepthDefault,
  localparam int unsigned AW = $clog2(BUF_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [BUF_DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rxrce_ctrl.sv
// ----------------------------------------------------------------------------
// rxrce_ctrl
// ring pointers, terminator count, drain sequencer and output register
// ----------------------------------------------------------------------------
module rxrce_ctrl #(
  parameter int unsigned BUF_DEPTH = rxrce_pkg::BufDepthDefault,
  localparam int unsigned AW = $clog2(BUF_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rxrce_pkg::in_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rxrce_pkg::out_t    out_data_o,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [7:0]         mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  logic [7:0]         mem_rdata_i,
  output rxrce_pkg::status_t status_o
);

  localparam logic [AW-1:0] LastIdx = AW'(BUF_DEPTH - 1);

  rxrce_pkg::state_e state_q, state_d;
  logic [AW-1:0]     wr_q, wr_d;
  logic [AW-1:0]     rd_q, rd_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  rxrce_pkg::out_t   out_q, out_d;
  logic [AW-1:0]     wr_next;
  logic [AW-1:0]     rd_next;
  logic              out_free;
  logic              in_acc;
  logic              is_crlf;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rxrce_pkg::StIdle;
      wr_q        <= '0;
      rd_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // wrapping pointer increments
  assign wr_next = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
  assign rd_next = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != rxrce_pkg::StIdle) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_crlf    = (mem_rdata_i == rxrce_pkg::CharCr) ||
                      (mem_rdata_i == rxrce_pkg::CharLf);

  // next state, pointer updates and memory accesses
  always_comb begin
    state_d     = state_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_wdata_o = in_data_i.rx_byte;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_q;

    case (state_q)
      rxrce_pkg::StIdle: begin
        if (in_acc) begin
          if (in_data_i.op == rxrce_pkg::OpByte) begin
            // store unless full, one slot kept empty
            if (wr_next != rd_q) begin
              mem_we_o = 1'b1;
              wr_d     = wr_next;
              if (in_data_i.rx_byte == rxrce_pkg::CharTerm) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
          end else if (cnt_q == '0) begin
            // no complete command held
            out_valid_d    = 1'b1;
            out_d.found    = 1'b0;
            out_d.cmd_char = 8'h00;
            out_d.last     = 1'b1;
          end else begin
            // prime the read of the oldest byte
            mem_re_o    = 1'b1;
            mem_raddr_o = rd_q;
            state_d     = rxrce_pkg::StDrain;
          end
        end
      end
      rxrce_pkg::StDrain: begin
        if (is_crlf) begin
          // skip line endings, no output slot needed
          rd_d        = rd_next;
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_next;
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.found    = 1'b1;
          out_d.cmd_char = mem_rdata_i;
          out_d.last     = (mem_rdata_i == rxrce_pkg::CharTerm);
          rd_d           = rd_next;
          if (mem_rdata_i == rxrce_pkg::CharTerm) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = rxrce_pkg::StIdle;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = rd_next;
          end
        end
      end
      default: begin
        state_d = rxrce_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign status_o.drain     = (state_q == rxrce_pkg::StDrain);
  assign status_o.term_zero = (cnt_q == '0);

endmodule

### src/rx_ring_command_extractor_unit.sv
// ----------------------------------------------------------------------------
// rx_ring_command_extractor_unit
// receive ring buffer that hands out ';'-terminated commands byte by byte
// ----------------------------------------------------------------------------
// A byte item is stored unless the ring already holds BUF_DEPTH-1 bytes.
// A fetch with no complete command held answers with one not-found result
// in the following cycle. A fetch that finds a command first primes the ring
// memory read and then drains the command byte by byte, skipping CR and LF,
// paced by the single read port of the ring memory and by any stall on the
// result side; input is stalled until the terminator is handed out. A count
// of stored terminators decides at once whether a command is held. The ring
// contents are not cleared after reset, so the block is ready straight away.
// ----------------------------------------------------------------------------
`include "rx_ring_command_extractor_unit_defines.svh"

module rx_ring_command_extractor_unit #(
  parameter int unsigned BUF_DEPTH = rxrce_pkg::BufDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rxrce_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rxrce_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;
  rxrce_pkg::status_t status;

  // sequencer and pointers
  rxrce_ctrl #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .status_o   (status)
  );

  // ring byte store
  rxrce_ring_mem #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_ring_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // checks
  `RXRCE_ASSERT_SAME(a_no_input_in_drain, status.drain, in_stall_o, "input taken while draining")
  `RXRCE_ASSERT_SAME(a_drain_has_term, status.drain, !status.term_zero, "drain with no terminator")
  `RXRCE_ASSERT_NEXT(a_not_found, in_valid_i && !in_stall_o && (in_data_i.op == rxrce_pkg::OpFetch) && status.term_zero, out_valid_o && !out_data_o.found && out_data_o.last, "not-found result missing")
  `RXRCE_ASSERT_SAME(a_drain_ends_on_term, $fell(status.drain), out_valid_o && out_data_o.found && out_data_o.last && (out_data_o.cmd_char == rxrce_pkg::CharTerm), "drain ended without terminator")

endmodule
